// ===== rtl/core/spectral_bin_freeze_crossfade_defines.svh =====
// ----------------------------------------------------------------------------
// Spectral bin freeze crossfade - assertion macros
// Assertion wrappers used by the top-level RTL file; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_BIN_FREEZE_CROSSFADE_DEFINES_SVH
`define SPECTRAL_BIN_FREEZE_CROSSFADE_DEFINES_SVH

`ifndef SYNTH

// consequent must hold in the same cycle as the antecedent
`define SBFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbfc assertion failed");

// consequent must hold in the cycle after the antecedent
`define SBFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbfc assertion failed");

`else

`define SBFC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SBFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/sbfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Spectral bin freeze crossfade - package
// Widths, reset values, register map and the types shared between modules.
// ----------------------------------------------------------------------------
package sbfc_pkg;

    // item field widths
    localparam int IDX_W  = 11;
    localparam int AMP_W  = 24;
    localparam int FREQ_W = 23;

    // fixed point
    localparam int COEF_W = 16;
    localparam int FRAC_W = 16;
    localparam int MIX_W  = 17;               // Q1.16, 0..1.0
    localparam int RAMP_W = 12;
    localparam int CNT_W  = 13;

    localparam logic [MIX_W-1:0] ONE_Q16 = MIX_W'(1 << FRAC_W);

    // blend unit operand and product widths
    localparam int OPD_W  = AMP_W;
    localparam int PROD_W = (OPD_W + 1) + (MIX_W + 1);

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [COEF_W-1:0] COEF_RST = '0;
    localparam logic [RAMP_W-1:0] RAMP_RST = RAMP_W'(187);

    localparam int FFT_SIZE_DEF = 2048;

    typedef enum logic [1:0] {
        REG_AMP_COEF  = 2'd0,
        REG_FREQ_COEF = 2'd1,
        REG_AMP_RAMP  = 2'd2,
        REG_FREQ_RAMP = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [COEF_W-1:0] amp_coef;
        logic [COEF_W-1:0] freq_coef;
        logic [RAMP_W-1:0] amp_ramp;
        logic [RAMP_W-1:0] freq_ramp;
    } t_cfg;

    // freeze controller state
    typedef struct packed {
        logic              frozen;
        logic [CNT_W-1:0]  attack;
        logic [CNT_W-1:0]  release_cnt;
        logic [COEF_W-1:0] coef;
        logic              goal;
    } t_ctrl_st;

    // blend operations, tag the result so it lands in the right register
    typedef enum logic [2:0] {
        OP_MIX_A = 3'd0,
        OP_MIX_F = 3'd1,
        OP_SM_A  = 3'd2,
        OP_SM_F  = 3'd3,
        OP_OUT_A = 3'd4,
        OP_OUT_F = 3'd5
    } t_op;

    typedef struct packed {
        logic             valid;
        t_op              op;
        logic [OPD_W-1:0] x;
        logic [OPD_W-1:0] y;
        logic [MIX_W-1:0] w;
    } t_blend_req;

    typedef struct packed {
        logic             valid;
        t_op              op;
        logic [OPD_W-1:0] res;
    } t_blend_rsp;

    // one row of the per-bin store
    typedef struct packed {
        logic [AMP_W-1:0]  held_amp;
        logic [FREQ_W-1:0] held_freq;
        logic [AMP_W-1:0]  sm_amp;
        logic [FREQ_W-1:0] sm_freq;
    } t_row;

endpackage

// ===== rtl/core/sbfc_regs.sv =====
// ----------------------------------------------------------------------------
// Spectral bin freeze crossfade - configuration registers
// APB-style register file: smoothing coefficients and ramp lengths.
// ----------------------------------------------------------------------------
module sbfc_regs
    import sbfc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_sel;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.amp_coef  <= COEF_RST;
            r_cfg.freq_coef <= COEF_RST;
            r_cfg.amp_ramp  <= RAMP_RST;
            r_cfg.freq_ramp <= RAMP_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_AMP_COEF:  r_cfg.amp_coef  <= pwdata[COEF_W-1:0];
                REG_FREQ_COEF: r_cfg.freq_coef <= pwdata[COEF_W-1:0];
                REG_AMP_RAMP:  r_cfg.amp_ramp  <= pwdata[RAMP_W-1:0];
                REG_FREQ_RAMP: r_cfg.freq_ramp <= pwdata[RAMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_AMP_COEF:  prdata = PDATA_W'(r_cfg.amp_coef);
            REG_FREQ_COEF: prdata = PDATA_W'(r_cfg.freq_coef);
            REG_AMP_RAMP:  prdata = PDATA_W'(r_cfg.amp_ramp);
            REG_FREQ_RAMP: prdata = PDATA_W'(r_cfg.freq_ramp);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/sbfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Spectral bin freeze crossfade - freeze controller
// Ramp counters, frozen flag, active coefficient and mix goal of one
// controller; steps once per frame start.
// ----------------------------------------------------------------------------
module sbfc_ctrl
    import sbfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_upd,
    input  logic              i_sw,
    input  logic [COEF_W-1:0] i_coef_reg,
    input  logic [RAMP_W-1:0] i_ramp,
    output t_ctrl_st          o_st
);

    t_ctrl_st         r_st;
    t_ctrl_st         n_st;
    logic [CNT_W-1:0] ramp_ext;

    assign ramp_ext = CNT_W'(i_ramp);

    always_comb begin
        n_st = r_st;
        if (i_upd) begin
            if (!r_st.frozen && i_sw) begin
                if (r_st.attack == '0) begin
                    n_st.coef = i_coef_reg;
                    n_st.goal = 1'b1;
                end
                if (r_st.attack > ramp_ext) begin
                    n_st.frozen = 1'b1;
                    n_st.coef   = '0;
                    n_st.attack = '0;
                end else begin
                    n_st.attack = r_st.attack + CNT_W'(1);
                end
            end
            if (!i_sw) begin
                // release: reload coefficient and restart the release count
                if (r_st.frozen) begin
                    n_st.coef        = i_coef_reg;
                    n_st.frozen      = 1'b0;
                    n_st.release_cnt = '0;
                    n_st.goal        = 1'b0;
                end
                if (n_st.release_cnt > ramp_ext) begin
                    n_st.coef = '0;
                end else begin
                    n_st.release_cnt = n_st.release_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

// ===== rtl/core/sbfc_blend.sv =====
// ----------------------------------------------------------------------------
// Spectral bin freeze crossfade - shared blend unit
// x*w + y*(1-w), rounded half up, as y + ((x-y)*w + 0.5) >> 16.
// Product registered; result is valid in the cycle after the request.
// ----------------------------------------------------------------------------
module sbfc_blend
    import sbfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_blend_req i_req,
    output t_blend_rsp o_rsp
);

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1 << (FRAC_W - 1));

    logic signed [OPD_W:0]    diff;
    logic signed [MIX_W:0]    w_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd;
    logic signed [PROD_W-1:0] sum;

    logic                     r_vld;
    t_op                      r_op;
    logic signed [PROD_W-1:0] r_prod;
    logic [OPD_W-1:0]         r_y;

    assign diff = $signed({1'b0, i_req.x}) - $signed({1'b0, i_req.y});
    assign w_s  = $signed({1'b0, i_req.w});
    assign prod = PROD_W'(diff) * PROD_W'(w_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= i_req.op;
        r_prod <= prod;
        r_y    <= i_req.y;
    end

    // arithmetic shift floors, which matches the rounding of the full sum
    assign rnd = (r_prod + RND_HALF) >>> FRAC_W;
    assign sum = rnd + PROD_W'($signed({1'b0, r_y}));

    assign o_rsp.valid = r_vld;
    assign o_rsp.op    = r_op;
    assign o_rsp.res   = sum[OPD_W-1:0];

endmodule

// ===== rtl/core/spectral_bin_freeze_crossfade.sv =====
// ----------------------------------------------------------------------------
// Spectral bin freeze crossfade - top level
// Freezes spectral bins with ramped crossfade between held and live values.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_ready   bin_index, bin_amp, bin_freq,
//                                                  freeze_amp_on, freeze_freq_on
//   out       output     o_out_valid / i_out_ready out_index, out_amp, out_freq,
//                                                  amp/freq_is_frozen
//   config    input      APB psel/penable/pready   4 registers at 0x0..0xC
//
// A bin in range passes ST_SMA, ST_SMF, ST_OA, ST_OF, ST_WB and ST_FIN after
// its accept with o_in_ready low; bin 0 first passes ST_CTRL, ST_MIXA and ST_MIXF;
// a bin past FFT_SIZE/2 goes straight to ST_FIN. One blend per cycle goes through
// the shared multiplier (6 blends for bin 0, 4 for other bins).
// After reset the FFT_SIZE/2+1 rows of the per-bin store (1025 by default) are
// cleared with o_in_ready low; config writes are taken meanwhile.
// A finished item waits in the output register; the next item is accepted
// meanwhile and stalls only when it is done while the output is still full.
// ----------------------------------------------------------------------------
`include "spectral_bin_freeze_crossfade_defines.svh"

module spectral_bin_freeze_crossfade
    import sbfc_pkg::*;
#(
    parameter int FFT_SIZE = FFT_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [IDX_W-1:0]   i_bin_index,
    input  logic [AMP_W-1:0]   i_bin_amp,
    input  logic [FREQ_W-1:0]  i_bin_freq,
    input  logic               i_freeze_amp_on,
    input  logic               i_freeze_freq_on,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [IDX_W-1:0]   o_out_index,
    output logic [AMP_W-1:0]   o_out_amp,
    output logic [FREQ_W-1:0]  o_out_freq,
    output logic               o_amp_is_frozen,
    output logic               o_freq_is_frozen,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int NB = FFT_SIZE / 2 + 1;
    localparam int AW = $clog2(NB);

    typedef enum logic [10:0] {
        ST_CLR  = 11'b000_0000_0001,
        ST_IDLE = 11'b000_0000_0010,
        ST_CTRL = 11'b000_0000_0100,
        ST_MIXA = 11'b000_0000_1000,
        ST_MIXF = 11'b000_0001_0000,
        ST_SMA  = 11'b000_0010_0000,
        ST_SMF  = 11'b000_0100_0000,
        ST_OA   = 11'b000_1000_0000,
        ST_OF   = 11'b001_0000_0000,
        ST_WB   = 11'b010_0000_0000,
        ST_FIN  = 11'b100_0000_0000
    } t_state;

    t_cfg       cfg;
    t_ctrl_st   amp_st;
    t_ctrl_st   freq_st;
    t_blend_req breq;
    t_blend_rsp brsp;

    t_state     r_state;
    t_state     n_state;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] n_clr_addr;
    logic [MIX_W-1:0] r_mix_a;
    logic [MIX_W-1:0] n_mix_a;
    logic [MIX_W-1:0] r_mix_f;
    logic [MIX_W-1:0] n_mix_f;
    logic       r_out_valid;
    logic       n_out_valid;

    // item payload
    logic [AW-1:0]     r_addr;
    logic [IDX_W-1:0]  r_idx;
    logic [AMP_W-1:0]  r_amp;
    logic [FREQ_W-1:0] r_freq;
    logic              r_sw_a;
    logic              r_sw_f;
    logic              r_in_rng;
    logic [AMP_W-1:0]  r_sa_new;
    logic [FREQ_W-1:0] r_sf_new;
    logic [AMP_W-1:0]  r_oa;
    logic [FREQ_W-1:0] r_of;

    logic [IDX_W-1:0]  r_out_index;
    logic [AMP_W-1:0]  r_out_amp;
    logic [FREQ_W-1:0] r_out_freq;
    logic              r_out_fa;
    logic              r_out_ff;

    // per-bin store
    t_row          r_mem [NB];
    t_row          r_rd_row;
    t_row          wr_row;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;

    logic              in_acc;
    logic              in_rng;
    logic              out_load;
    logic [AMP_W-1:0]  held_a_new;
    logic [FREQ_W-1:0] held_f_new;

    sbfc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sbfc_ctrl u_ctrl_amp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_upd      (r_state == ST_CTRL),
        .i_sw       (r_sw_a),
        .i_coef_reg (cfg.amp_coef),
        .i_ramp     (cfg.amp_ramp),
        .o_st       (amp_st)
    );

    sbfc_ctrl u_ctrl_freq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_upd      (r_state == ST_CTRL),
        .i_sw       (r_sw_f),
        .i_coef_reg (cfg.freq_coef),
        .i_ramp     (cfg.freq_ramp),
        .o_st       (freq_st)
    );

    sbfc_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (breq),
        .o_rsp   (brsp)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_rng     = (32'(i_bin_index) < 32'(NB));
    assign out_load   = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);

    // frozen flags are already updated for this frame when these are used
    assign held_a_new = amp_st.frozen  ? r_rd_row.held_amp  : r_amp;
    assign held_f_new = freq_st.frozen ? r_rd_row.held_freq : r_freq;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        case (r_state)
            ST_CLR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(NB - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_bin_index == '0) begin
                        n_state = ST_CTRL;
                    end else if (in_rng) begin
                        n_state = ST_SMA;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_CTRL: n_state = ST_MIXA;
            ST_MIXA: n_state = ST_MIXF;
            ST_MIXF: n_state = r_in_rng ? ST_SMA : ST_FIN;
            ST_SMA:  n_state = ST_SMF;
            ST_SMF:  n_state = ST_OA;
            ST_OA:   n_state = ST_OF;
            ST_OF:   n_state = ST_WB;
            ST_WB:   n_state = ST_FIN;
            ST_FIN: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // one blend request per cycle
    always_comb begin
        breq = '0;
        case (r_state)
            ST_MIXA: begin
                breq.valid = 1'b1;
                breq.op    = OP_MIX_A;
                breq.x     = OPD_W'(amp_st.goal ? ONE_Q16 : '0);
                breq.y     = OPD_W'(r_mix_a);
                breq.w     = ONE_Q16 - MIX_W'(amp_st.coef);
            end
            ST_MIXF: begin
                breq.valid = 1'b1;
                breq.op    = OP_MIX_F;
                breq.x     = OPD_W'(freq_st.goal ? ONE_Q16 : '0);
                breq.y     = OPD_W'(r_mix_f);
                breq.w     = ONE_Q16 - MIX_W'(freq_st.coef);
            end
            ST_SMA: begin
                breq.valid = 1'b1;
                breq.op    = OP_SM_A;
                breq.x     = r_rd_row.sm_amp;
                breq.y     = held_a_new;
                breq.w     = MIX_W'(amp_st.coef);
            end
            ST_SMF: begin
                breq.valid = 1'b1;
                breq.op    = OP_SM_F;
                breq.x     = OPD_W'(r_rd_row.sm_freq);
                breq.y     = OPD_W'(held_f_new);
                breq.w     = MIX_W'(freq_st.coef);
            end
            ST_OA: begin
                breq.valid = 1'b1;
                breq.op    = OP_OUT_A;
                breq.x     = r_sa_new;
                breq.y     = r_amp;
                breq.w     = r_mix_a;
            end
            ST_OF: begin
                breq.valid = 1'b1;
                breq.op    = OP_OUT_F;
                breq.x     = OPD_W'(r_sf_new);
                breq.y     = OPD_W'(r_freq);
                breq.w     = r_mix_f;
            end
            default: breq = '0;
        endcase
    end

    assign n_mix_a = (brsp.valid && brsp.op == OP_MIX_A) ? brsp.res[MIX_W-1:0] : r_mix_a;
    assign n_mix_f = (brsp.valid && brsp.op == OP_MIX_F) ? brsp.res[MIX_W-1:0] : r_mix_f;
    assign n_out_valid = out_load || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr_addr  <= '0;
            r_mix_a     <= '0;
            r_mix_f     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_mix_a     <= n_mix_a;
            r_mix_f     <= n_mix_f;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_addr   <= AW'(i_bin_index);
            r_idx    <= i_bin_index;
            r_amp    <= i_bin_amp;
            r_freq   <= i_bin_freq;
            r_sw_a   <= i_freeze_amp_on;
            r_sw_f   <= i_freeze_freq_on;
            r_in_rng <= in_rng;
        end
        if (brsp.valid) begin
            case (brsp.op)
                OP_SM_A:  r_sa_new <= brsp.res;
                OP_SM_F:  r_sf_new <= brsp.res[FREQ_W-1:0];
                OP_OUT_A: r_oa     <= brsp.res;
                OP_OUT_F: r_of     <= brsp.res[FREQ_W-1:0];
                default: ;
            endcase
        end
        if (out_load) begin
            r_out_index <= r_idx;
            r_out_amp   <= r_in_rng ? r_oa : r_amp;
            r_out_freq  <= r_in_rng ? r_of : r_freq;
            r_out_fa    <= amp_st.frozen;
            r_out_ff    <= freq_st.frozen;
        end
    end

    // store access: clear sweep after reset, read on accept, write back at end
    assign mem_we    = (r_state == ST_CLR) || (r_state == ST_WB);
    assign mem_waddr = (r_state == ST_CLR) ? r_clr_addr : r_addr;

    always_comb begin
        if (r_state == ST_CLR) begin
            wr_row = '0;
        end else begin
            wr_row.held_amp  = held_a_new;
            wr_row.held_freq = held_f_new;
            wr_row.sm_amp    = r_sa_new;
            wr_row.sm_freq   = r_sf_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= wr_row;
        end
        if (in_acc && in_rng) begin
            r_rd_row <= r_mem[AW'(i_bin_index)];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_index      = r_out_index;
    assign o_out_amp        = r_out_amp;
    assign o_out_freq       = r_out_freq;
    assign o_amp_is_frozen  = r_out_fa;
    assign o_freq_is_frozen = r_out_ff;

    `SBFC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !o_in_ready)
    `SBFC_ASSERT_SAME(a_blend_only_busy, i_clk, i_rst_n, brsp.valid, r_state != ST_IDLE && r_state != ST_CLR)
    `SBFC_ASSERT_SAME(a_out_from_fin, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == ST_FIN)
    `SBFC_ASSERT_SAME(a_freeze_in_ctrl, i_clk, i_rst_n, $past(i_rst_n) && (!$stable(amp_st.frozen) || !$stable(freq_st.frozen)), $past(r_state) == ST_CTRL)

endmodule

// ===== sim/spectral_bin_freeze_crossfade_chk.sv =====
// ----------------------------------------------------------------------------
// Spectral bin freeze crossfade - result checker
// Watches the config port and both item channels, keeps its own copy of the
// freeze controllers and per-bin stores, predicts every result and compares
// each accepted result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module spectral_bin_freeze_crossfade_chk
    import sbfc_pkg::*;
#(
    parameter int FFT_SIZE = FFT_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [IDX_W-1:0]   i_bin_index,
    input  logic [AMP_W-1:0]   i_bin_amp,
    input  logic [FREQ_W-1:0]  i_bin_freq,
    input  logic               i_freeze_amp_on,
    input  logic               i_freeze_freq_on,

    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [IDX_W-1:0]   i_out_index,
    input  logic [AMP_W-1:0]   i_out_amp,
    input  logic [FREQ_W-1:0]  i_out_freq,
    input  logic               i_amp_is_frozen,
    input  logic               i_freq_is_frozen,

    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    input  logic               i_pready,

    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int NUM_BINS = FFT_SIZE / 2 + 1;

    typedef struct packed {
        logic              frozen;
        logic [CNT_W-1:0]  attack;
        logic [CNT_W-1:0]  rel_cnt;
        logic [COEF_W-1:0] coef;
        logic              goal;
        logic [MIX_W-1:0]  mix;
    } frz_ctrl_t;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [AMP_W-1:0]  amp;
        logic [FREQ_W-1:0] freq;
        logic              amp_frz;
        logic              freq_frz;
    } faded_bin_t;

    t_cfg       cfg_shadow;
    frz_ctrl_t  amp_ctl;
    frz_ctrl_t  freq_ctl;

    logic [AMP_W-1:0]  hold_amp   [0:NUM_BINS-1];
    logic [FREQ_W-1:0] hold_freq  [0:NUM_BINS-1];
    logic [AMP_W-1:0]  glide_amp  [0:NUM_BINS-1];
    logic [FREQ_W-1:0] glide_freq [0:NUM_BINS-1];

    faded_bin_t faded_bins_q [$];
    faded_bin_t want;
    faded_bin_t got;
    int         err_cnt = 0;
    int         n;

    // x*w + y*(1-w) in Q1.16, rounded half up
    function automatic logic [AMP_W-1:0] blend_q16(logic [AMP_W-1:0] x, logic [AMP_W-1:0] y,
                                                   logic [MIX_W-1:0] w);
        logic [63:0] acc;
        acc = 64'(x) * 64'(w) + 64'(y) * (64'(ONE_Q16) - 64'(w)) + 64'd32768;
        return acc[AMP_W+FRAC_W-1:FRAC_W];
    endfunction

    function automatic frz_ctrl_t step_ctrl(frz_ctrl_t c, logic sw, logic [COEF_W-1:0] coef_reg,
                                            logic [RAMP_W-1:0] ramp);
        if (!c.frozen && sw) begin
            if (c.attack == '0) begin
                c.coef = coef_reg;
                c.goal = 1'b1;
            end
            if (c.attack > CNT_W'(ramp)) begin
                c.frozen = 1'b1;
                c.coef   = '0;
                c.attack = '0;
            end else begin
                c.attack = c.attack + CNT_W'(1);
            end
        end
        if (!sw) begin
            // release reloads the ramp, attack count is kept
            if (c.frozen) begin
                c.coef    = coef_reg;
                c.frozen  = 1'b0;
                c.rel_cnt = '0;
                c.goal    = 1'b0;
            end
            if (c.rel_cnt > CNT_W'(ramp)) begin
                c.coef = '0;
            end else begin
                c.rel_cnt = c.rel_cnt + CNT_W'(1);
            end
        end
        c.mix = MIX_W'(blend_q16(c.goal ? AMP_W'(ONE_Q16) : '0, AMP_W'(c.mix),
                                 ONE_Q16 - MIX_W'(c.coef)));
        return c;
    endfunction

    task automatic fade_bin(input logic [IDX_W-1:0] idx, input logic [AMP_W-1:0] amp,
                            input logic [FREQ_W-1:0] freq, input logic sw_a, input logic sw_f,
                            output faded_bin_t r);
        logic [AMP_W-1:0]  oa;
        logic [FREQ_W-1:0] of;
        oa = amp;
        of = freq;
        if (idx == '0) begin
            amp_ctl  = step_ctrl(amp_ctl, sw_a, cfg_shadow.amp_coef, cfg_shadow.amp_ramp);
            freq_ctl = step_ctrl(freq_ctl, sw_f, cfg_shadow.freq_coef, cfg_shadow.freq_ramp);
        end
        // bins past the end bypass the stores
        if (idx < NUM_BINS) begin
            if (!amp_ctl.frozen)
                hold_amp[idx] = amp;
            if (!freq_ctl.frozen)
                hold_freq[idx] = freq;
            glide_amp[idx]  = blend_q16(glide_amp[idx], hold_amp[idx], MIX_W'(amp_ctl.coef));
            glide_freq[idx] = FREQ_W'(blend_q16(AMP_W'(glide_freq[idx]), AMP_W'(hold_freq[idx]),
                                                MIX_W'(freq_ctl.coef)));
            oa = blend_q16(glide_amp[idx], amp, amp_ctl.mix);
            of = FREQ_W'(blend_q16(AMP_W'(glide_freq[idx]), AMP_W'(freq), freq_ctl.mix));
        end
        r.index    = idx;
        r.amp      = oa;
        r.freq     = of;
        r.amp_frz  = amp_ctl.frozen;
        r.freq_frz = freq_ctl.frozen;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_shadow.amp_coef  = COEF_RST;
            cfg_shadow.freq_coef = COEF_RST;
            cfg_shadow.amp_ramp  = RAMP_RST;
            cfg_shadow.freq_ramp = RAMP_RST;
            amp_ctl  = '0;
            freq_ctl = '0;
            for (n = 0; n < NUM_BINS; n++) begin
                hold_amp[n]   = '0;
                hold_freq[n]  = '0;
                glide_amp[n]  = '0;
                glide_freq[n] = '0;
            end
            faded_bins_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_AMP_COEF:  cfg_shadow.amp_coef  = i_pwdata[COEF_W-1:0];
                    REG_FREQ_COEF: cfg_shadow.freq_coef = i_pwdata[COEF_W-1:0];
                    REG_AMP_RAMP:  cfg_shadow.amp_ramp  = i_pwdata[RAMP_W-1:0];
                    REG_FREQ_RAMP: cfg_shadow.freq_ramp = i_pwdata[RAMP_W-1:0];
                    default: ;
                endcase
            end

            // results first: a result never belongs to the item taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (faded_bins_q.size() == 0) begin
                    err_cnt++;
                    $error("result with no item outstanding: index %0d", i_out_index);
                end else begin
                    want = faded_bins_q.pop_front();
                    got.index    = i_out_index;
                    got.amp      = i_out_amp;
                    got.freq     = i_out_freq;
                    got.amp_frz  = i_amp_is_frozen;
                    got.freq_frz = i_freq_is_frozen;
                    if (got.index !== want.index) begin
                        err_cnt++;
                        $error("out_index: expected %0d, got %0d", want.index, got.index);
                    end
                    if (got.amp !== want.amp) begin
                        err_cnt++;
                        $error("out_amp: expected %06h, got %06h", want.amp, got.amp);
                    end
                    if (got.freq !== want.freq) begin
                        err_cnt++;
                        $error("out_freq: expected %06h, got %06h", want.freq, got.freq);
                    end
                    if (got.amp_frz !== want.amp_frz) begin
                        err_cnt++;
                        $error("amp_is_frozen: expected %0b, got %0b", want.amp_frz,
                               got.amp_frz);
                    end
                    if (got.freq_frz !== want.freq_frz) begin
                        err_cnt++;
                        $error("freq_is_frozen: expected %0b, got %0b", want.freq_frz,
                               got.freq_frz);
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                fade_bin(i_bin_index, i_bin_amp, i_bin_freq, i_freeze_amp_on,
                         i_freeze_freq_on, want);
                faded_bins_q.push_back(want);
            end
        end
        o_pending    <= faded_bins_q.size();
        o_fail_count <= err_cnt;
    end

endmodule

// ===== sim/spectral_bin_freeze_crossfade_tb.sv =====
// ----------------------------------------------------------------------------
// Spectral bin freeze crossfade - testbench top
// Programs the registers between phases, sends a directed run of frames and
// then random frames under three idle patterns, with one long output stall
// and one full drain mid-phase; the checker module predicts and compares.
// ----------------------------------------------------------------------------
module spectral_bin_freeze_crossfade_tb;
    import sbfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 105;
    localparam int NUM_PHASES     = 6;
    localparam int STALL_CYCLES   = 300;

    logic               i_clk;
    logic               i_rst_n        = 1'b0;

    logic               in_valid       = 1'b0;
    logic               in_ready;
    logic [IDX_W-1:0]   bin_index      = '0;
    logic [AMP_W-1:0]   bin_amp        = '0;
    logic [FREQ_W-1:0]  bin_freq       = '0;
    logic               freeze_amp_on  = 1'b0;
    logic               freeze_freq_on = 1'b0;

    logic               out_valid;
    logic               out_ready      = 1'b0;
    logic [IDX_W-1:0]   out_index;
    logic [AMP_W-1:0]   out_amp;
    logic [FREQ_W-1:0]  out_freq;
    logic               amp_is_frozen;
    logic               freq_is_frozen;

    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [PADDR_W-1:0] paddr          = '0;
    logic [PDATA_W-1:0] pwdata         = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len      = 0;
    int idle_cycles   = 0;
    int phase;

    spectral_bin_freeze_crossfade DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_bin_index      (bin_index),
        .i_bin_amp        (bin_amp),
        .i_bin_freq       (bin_freq),
        .i_freeze_amp_on  (freeze_amp_on),
        .i_freeze_freq_on (freeze_freq_on),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_out_index      (out_index),
        .o_out_amp        (out_amp),
        .o_out_freq       (out_freq),
        .o_amp_is_frozen  (amp_is_frozen),
        .o_freq_is_frozen (freq_is_frozen),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    spectral_bin_freeze_crossfade_chk u_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_bin_index      (bin_index),
        .i_bin_amp        (bin_amp),
        .i_bin_freq       (bin_freq),
        .i_freeze_amp_on  (freeze_amp_on),
        .i_freeze_freq_on (freeze_freq_on),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_index      (out_index),
        .i_out_amp        (out_amp),
        .i_out_freq       (out_freq),
        .i_amp_is_frozen  (amp_is_frozen),
        .i_freq_is_frozen (freq_is_frozen),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_pready         (pready),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result side: random back-pressure, or a counted long stall when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                out_ready <= 1'b0;
                hold_len--;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("spectral_bin_freeze_crossfade_tb: done, errors");
        $finish;
    end

    task automatic apb_write(t_reg_idx r, logic [PDATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_regs(logic [COEF_W-1:0] amp_coef, logic [COEF_W-1:0] freq_coef,
                                logic [RAMP_W-1:0] amp_ramp, logic [RAMP_W-1:0] freq_ramp);
        apb_write(REG_AMP_COEF, PDATA_W'(amp_coef));
        apb_write(REG_FREQ_COEF, PDATA_W'(freq_coef));
        apb_write(REG_AMP_RAMP, PDATA_W'(amp_ramp));
        apb_write(REG_FREQ_RAMP, PDATA_W'(freq_ramp));
    endtask

    // valid drops only ahead of a gap, so it is never lowered and raised in one step
    task automatic send_bin(logic [IDX_W-1:0] idx, logic [AMP_W-1:0] amp,
                            logic [FREQ_W-1:0] freq, logic sw_a, logic sw_f);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid       <= 1'b1;
        bin_index      <= idx;
        bin_amp        <= amp;
        bin_freq       <= freq;
        freeze_amp_on  <= sw_a;
        freeze_freq_on <= sw_f;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    function automatic logic [AMP_W-1:0] rand_level(int width);
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return AMP_W'((1 << width) - 1);
        else if (r < 20)
            return '0;
        return AMP_W'($urandom & ((1 << width) - 1));
    endfunction

    task automatic run_frames(int n_items, int stall_at, int drain_at);
        int sent;
        int nb;
        int k;
        int r;
        logic sw_a;
        logic sw_f;
        logic [IDX_W-1:0] idx;
        sent = 0;
        sw_a = 1'($urandom_range(1));
        sw_f = 1'($urandom_range(1));
        while (sent < n_items) begin
            if ($urandom_range(99) < 20)
                sw_a = ~sw_a;
            if ($urandom_range(99) < 20)
                sw_f = ~sw_f;
            if (stall_at >= 0 && sent >= stall_at) begin
                hold_len = STALL_CYCLES;
                stall_at = -1;
            end
            if (drain_at >= 0 && sent >= drain_at) begin
                drain_results();
                drain_at = -1;
            end
            send_bin('0, rand_level(AMP_W), FREQ_W'(rand_level(FREQ_W)), sw_a, sw_f);
            sent++;
            nb = $urandom_range(1, 6);
            for (k = 0; k < nb; k++) begin
                r = $urandom_range(99);
                if (r < 75)
                    idx = IDX_W'($urandom_range(1, 8));
                else if (r < 88)
                    idx = IDX_W'($urandom_range(0, 1024));
                else if (r < 96)
                    idx = IDX_W'($urandom_range(1025, 2047));
                else
                    idx = '0;       // stray frame start, switches are random here
                send_bin(idx, rand_level(AMP_W), FREQ_W'(rand_level(FREQ_W)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    initial begin
        logic [COEF_W-1:0] ac;
        logic [COEF_W-1:0] fc;
        logic [RAMP_W-1:0] ar;
        logic [RAMP_W-1:0] fr;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: amp ramps in one frame pair, freq needs three frame starts
        program_regs(16'hFFFF, 16'h0000, 12'd0, 12'd1);
        send_bin(11'd0,    24'hFFFFFF, 23'h7FFFFF, 1'b1, 1'b1);
        send_bin(11'd1024, 24'hFFFFFF, 23'h7FFFFF, 1'b1, 1'b1);
        send_bin(11'd1025, 24'hFFFFFF, 23'h7FFFFF, 1'b1, 1'b1);
        send_bin(11'd2047, 24'h000000, 23'h000000, 1'b0, 1'b0);
        send_bin(11'd0,    24'h123456, 23'h654321, 1'b1, 1'b1);
        send_bin(11'd0,    24'h000000, 23'h000000, 1'b1, 1'b1);
        send_bin(11'd1,    24'h000000, 23'h000000, 1'b0, 1'b0);
        send_bin(11'd1024, 24'h5A5A5A, 23'h2A5A5A, 1'b1, 1'b0);
        send_bin(11'd0,    24'hFFFFFF, 23'h7FFFFF, 1'b0, 1'b1);
        send_bin(11'd1,    24'hABCDEF, 23'h1BCDEF, 1'b0, 1'b0);
        send_bin(11'd0,    24'h000001, 23'h000001, 1'b0, 1'b0);
        send_bin(11'd0,    24'h800000, 23'h400000, 1'b1, 1'b0);
        send_bin(11'd3,    24'h7FFFFF, 23'h3FFFFF, 1'b0, 1'b0);
        // release before the freeze completes, then freeze again
        send_bin(11'd0,    24'h00FF00, 23'h00FF00, 1'b0, 1'b0);
        send_bin(11'd0,    24'hFF00FF, 23'h7F00FF, 1'b1, 1'b0);
        send_bin(11'd3,    24'hFFFFFF, 23'h7FFFFF, 1'b1, 1'b1);
        send_bin(11'd0,    24'h0F0F0F, 23'h0F0F0F, 1'b0, 1'b1);
        send_bin(11'd1024, 24'hA5A5A5, 23'h5A5A5A, 1'b0, 1'b0);
        send_bin(11'd512,  24'hFFFFFF, 23'h000000, 1'b0, 1'b0);
        send_bin(11'd0,    24'h000000, 23'h7FFFFF, 1'b1, 1'b0);
        send_bin(11'd1023, 24'h000000, 23'h7FFFFF, 1'b0, 1'b0);
        send_bin(11'd1025, 24'h000000, 23'h000000, 1'b1, 1'b1);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            case (phase / 2)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 64;
                end
                1: begin
                    send_idle_pct = 64;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            ac = COEF_W'($urandom);
            fc = COEF_W'($urandom);
            ar = RAMP_W'($urandom_range(0, 5));
            fr = RAMP_W'($urandom_range(0, 5));
            if (phase == 1) begin
                ac = 16'h0000;
                fc = 16'hFFFF;
                ar = 12'd4095;
                fr = 12'd0;
            end else if (phase == 3) begin
                ac = 16'hFFFF;
                fc = 16'h0000;
                ar = 12'd0;
                fr = 12'd4095;
            end
            program_regs(ac, fc, ar, fr);
            run_frames(PHASE_ITEMS, (phase == 4) ? PHASE_ITEMS / 3 : -1,
                       (phase == 5) ? PHASE_ITEMS / 2 : -1);
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("spectral_bin_freeze_crossfade_tb: done, clean");
        else
            $display("spectral_bin_freeze_crossfade_tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sbfc_pkg.sv
rtl/core/sbfc_regs.sv
rtl/core/sbfc_ctrl.sv
rtl/core/sbfc_blend.sv
rtl/core/spectral_bin_freeze_crossfade.sv
sim/spectral_bin_freeze_crossfade_chk.sv
sim/spectral_bin_freeze_crossfade_tb.sv
